// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// empty bodies when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/u8v_pkg.sv =====
// ----------------------------------------------------------------------------
// u8v_pkg: shared types and constants
// byte classes and decode result for the utf-8 stream check
// ----------------------------------------------------------------------------
`default_nettype none

package u8v_pkg;

  localparam int unsigned PendW = 2;

  typedef logic [PendW-1:0] pend_t;

  localparam logic [7:0] AsciiMax   = 8'h7F;
  localparam logic [7:0] LeadMin    = 8'hC2;
  localparam logic [7:0] LeadMax    = 8'hF4;
  localparam logic [7:0] Mask2      = 8'hE0;
  localparam logic [7:0] Lead2      = 8'hC0;
  localparam logic [7:0] Mask3      = 8'hF0;
  localparam logic [7:0] Lead3      = 8'hE0;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContVal    = 8'h80;
  localparam logic [7:0] Mask4      = 8'hF8;

  localparam pend_t PendNone  = 2'd0;
  localparam pend_t PendOne   = 2'd1;
  localparam pend_t PendTwo   = 2'd2;
  localparam pend_t PendThree = 2'd3;

  typedef struct packed {
    pend_t pend;
    logic  err;
  } dec_t;

endpackage

`default_nettype wire

// ===== rtl/core/u8v_decode.sv =====
// ----------------------------------------------------------------------------
// u8v_decode: byte classifier
// next pending count and error flag for one byte given the pending count
// ----------------------------------------------------------------------------
`default_nettype none

module u8v_decode (
  input  u8v_pkg::pend_t pend_i,
  input  logic [7:0]     byte_i,
  output u8v_pkg::dec_t  dec_o
);
  import u8v_pkg::*;

  always_comb begin
    dec_o.pend = pend_i;
    dec_o.err  = 1'b0;
    if (pend_i != PendNone) begin
      dec_o.err  = ((byte_i & ContMask) != ContVal);
      dec_o.pend = pend_i - PendOne;
    end else if (byte_i > AsciiMax) begin
      if ((byte_i < LeadMin) || (byte_i > LeadMax)) begin
        dec_o.err = 1'b1;
      end else if ((byte_i & Mask2) == Lead2) begin
        dec_o.pend = PendOne;
      end else if ((byte_i & Mask3) == Lead3) begin
        dec_o.pend = PendTwo;
      end else begin
        dec_o.pend = PendThree;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_stream_validator_core.sv =====
// result path: the last word of a string passes the input register, then the
// result register that drives string_valid_o; a stalled result keeps it waiting
// throughput: one word per cycle; the input register moves on each cycle
// unless a last word waits for a stalled result register
// reset: asynchronous, clears pending count, error flag and both valid bits
// ----------------------------------------------------------------------------
// utf8_stream_validator_core: streaming utf-8 string check
// one word per cycle unless the input is stalled, one result per string on its last word
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_validator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       string_valid_o
);
  import u8v_pkg::*;

`include "assert_macros.svh"

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  pend_t      pend_q, pend_d;
  logic       err_q, err_d;
  logic       out_valid_q, out_valid_d;
  logic       string_q, string_d;
  logic       out_free;
  logic       s1_go;
  logic       s1_fire;
  logic       in_fire;
  dec_t       dec;

  u8v_decode u_decode (
    .pend_i (pend_q),
    .byte_i (byte_q),
    .dec_o  (dec)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = !in_valid_q || !last_q || out_free;
  assign s1_fire    = in_valid_q && s1_go;
  assign in_stall_o = !s1_go;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    pend_d      = pend_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    string_d    = string_q;
    if (s1_fire) begin
      if (last_q) begin
        pend_d      = PendNone;
        err_d       = 1'b0;
        out_valid_d = 1'b1;
        string_d    = !(err_q || dec.err) && (dec.pend == PendNone);
      end else begin
        pend_d = dec.pend;
        err_d  = err_q || dec.err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pend_q      <= PendNone;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_go) begin
        in_valid_q <= in_valid_i;
      end
      pend_q      <= pend_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    string_q <= string_d;
  end

  assign out_valid_o    = out_valid_q;
  assign string_valid_o = string_q;

  `ASSERT_NEXT(a_last_clears, clk_i, rst_ni, s1_fire && last_q,
               (pend_q == PendNone) && !err_q)
  `ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, s1_fire && last_q, out_valid_q)
  `ASSERT_NEXT(a_err_gives_fail, clk_i, rst_ni, s1_fire && last_q && err_q, !string_q)
  `ASSERT_IMPLIES(a_stall_only_last, clk_i, rst_ni, in_stall_o,
                  in_valid_q && last_q && out_valid_q)

endmodule

`default_nettype wire
